[sv/m2h_pkg.sv]
// Shared types and constants for the MurmurHash2 stream hasher.
// Used by the front, queue, back and top-level modules; depends on nothing.
package m2h_pkg;

  localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
  localparam int unsigned MIX_SHIFT   = 24;
  localparam int unsigned FIN_SHIFT_A = 13;
  localparam int unsigned FIN_SHIFT_B = 15;
  localparam logic [31:0] SEED_RESET  = 32'd42;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_IDX_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_FULL = 2'd1,
    OP_TAIL = 2'd2
  } m2h_kind_t;

  // One classified word on its way from the front to the back.
  typedef struct packed {
    m2h_kind_t   kind;
    logic        first;
    logic        last;
    logic [31:0] init;
    logic [31:0] data;
  } m2h_op_t;

  typedef struct packed {
    logic popping;
    logic finalising;
  } m2h_back_stat_t;

endpackage

[sv/murmur2_hash_stream_top.sv]
// 32-bit MurmurHash2 over a word stream: front end, word queue and back end.
// Depends on m2h_pkg, m2h_front, m2h_queue and m2h_back.
//
// Usage: words enter through push/full, one message at a time, first word
// flagged by in_first_word together with the total byte length. Each word
// carries 0 to 4 bytes; only the last word may be partial. A word is taken
// at a clock edge with push high and full low. A word that arrives while no
// message is open and is not a first word is dropped silently.
// The hash of a message appears on out_hash_value while empty is low and
// is taken with pop. cfg_wr_en/cfg_wr_data set the seed (42 after reset)
// and may only be written while the block is idle.
// The closing word passes through front stages s1 and s2, the queue, the hash
// register, the finalisation register and the result register before empty
// goes low. Throughput: one word per cycle while no message closes; the
// closing word holds the back end through fold, finalise multiply and result
// load, and stays in result load until the result register is free.
// A four-entry queue decouples the pre-mixing pipe from the hash recurrence.
// Reset (synchronous, rst_n low) empties all stages, closes any message and
// restores the seed. If the result is not popped the back end stalls on
// the next closing word, the queue fills and full rises.
module murmur2_hash_stream_top import m2h_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_first_word,
  input  logic        in_last_word,
  input  logic [31:0] in_message_length,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_hash_value
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  m2h_op_t        q_push_op;
  m2h_op_t        q_pop_op;
  m2h_back_stat_t back_stat;

  m2h_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .push              (push),
    .full              (full),
    .in_data_word      (in_data_word),
    .in_byte_count     (in_byte_count),
    .in_first_word     (in_first_word),
    .in_last_word      (in_last_word),
    .in_message_length (in_message_length),
    .q_push            (q_push),
    .q_op              (q_push_op),
    .q_full            (q_full)
  );

  m2h_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_push    (q_push),
    .q_push_op (q_push_op),
    .q_full    (q_full),
    .q_pop     (q_pop),
    .q_pop_op  (q_pop_op),
    .q_empty   (q_empty)
  );

  m2h_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_op           (q_pop_op),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_hash_value (out_hash_value),
    .stat           (back_stat)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("word queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("word queue read while empty");

  a_no_fold_while_finalising: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.finalising |-> !back_stat.popping)
    else $error("back end took a word while finalising");

  a_closing_word_finalises: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_pop_op.last) |=> back_stat.finalising)
    else $error("closing word did not start finalisation");

endmodule

[sv/m2h_front.sv]
// Front end: accepts words, tracks the open message and pre-mixes full words.
// Two multiplier stages; depends on m2h_pkg.
module m2h_front import m2h_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_first_word,
  input  logic        in_last_word,
  input  logic [31:0] in_message_length,
  output logic        q_push,
  output m2h_op_t     q_op,
  input  logic        q_full
);

  logic [31:0] seed_r;
  logic        in_msg_r, in_msg_nxt;
  logic        s1_valid_r, s1_valid_nxt;
  m2h_op_t     s1_op_r;
  logic        s2_valid_r, s2_valid_nxt;
  m2h_op_t     s2_op_r;

  logic        advance;
  logic        accept;
  logic        keep;
  logic [31:0] tail_mask;
  logic [31:0] k_mul;
  logic [31:0] k_mid;
  logic [31:0] k_mix;
  m2h_op_t     s1_op_nxt;
  m2h_op_t     s2_op_nxt;

  // The whole pipe moves together whenever its last stage can empty.
  assign advance = !s2_valid_r || !q_full;
  assign full    = !advance;
  assign accept  = push && advance;
  assign keep    = in_first_word || in_msg_r;
  assign q_push  = s2_valid_r && !q_full;
  assign q_op    = s2_op_r;

  always_comb begin
    unique case (in_byte_count[1:0])
      2'd1:    tail_mask = 32'h0000_00ff;
      2'd2:    tail_mask = 32'h0000_ffff;
      2'd3:    tail_mask = 32'h00ff_ffff;
      default: tail_mask = 32'h0000_0000;
    endcase
  end

  assign k_mul = in_data_word * MIX_MUL;
  assign k_mid = s1_op_r.data ^ (s1_op_r.data >> MIX_SHIFT);
  assign k_mix = k_mid * MIX_MUL;

  always_comb begin
    s1_op_nxt.first = in_first_word;
    s1_op_nxt.last  = in_last_word;
    s1_op_nxt.init  = seed_r ^ in_message_length;
    if (in_byte_count[2]) begin
      s1_op_nxt.kind = OP_FULL;
      s1_op_nxt.data = k_mul;
    end else if (in_byte_count[1:0] != 2'd0) begin
      s1_op_nxt.kind = OP_TAIL;
      s1_op_nxt.data = in_data_word & tail_mask;
    end else begin
      s1_op_nxt.kind = OP_NONE;
      s1_op_nxt.data = in_data_word;
    end

    s2_op_nxt = s1_op_r;
    if (s1_op_r.kind == OP_FULL) begin
      s2_op_nxt.data = k_mix;
    end

    in_msg_nxt   = in_msg_r;
    s1_valid_nxt = s1_valid_r;
    s2_valid_nxt = s2_valid_r;
    if (advance) begin
      s1_valid_nxt = accept && keep;
      s2_valid_nxt = s1_valid_r;
    end
    if (accept && keep) begin
      in_msg_nxt = !in_last_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r     <= SEED_RESET;
      in_msg_r   <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      in_msg_r   <= in_msg_nxt;
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op_r <= s1_op_nxt;
      s2_op_r <= s2_op_nxt;
    end
  end

endmodule

[sv/m2h_queue.sv]
// Short queue of classified words between the front and the back.
// Depends on m2h_pkg for the entry type and depth.
module m2h_queue import m2h_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_push,
  input  m2h_op_t q_push_op,
  output logic    q_full,
  input  logic    q_pop,
  output m2h_op_t q_pop_op,
  output logic    q_empty
);

  m2h_op_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_IDX_W:0]   count_r, count_nxt;

  assign q_full   = (count_r == QUEUE_IDX_W'(0) + (QUEUE_IDX_W+1)'(QUEUE_DEPTH));
  assign q_empty  = (count_r == '0);
  assign q_pop_op = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (q_push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (q_pop && !q_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      mem_r[wr_ptr_r] <= q_push_op;
    end
  end

endmodule

[sv/m2h_back.sv]
// Back end: folds words into the running hash, finalises and holds the result.
// One multiplier in the hash recurrence and one for finalisation; depends on m2h_pkg.
module m2h_back import m2h_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  m2h_op_t        q_op,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic [31:0]    out_hash_value,
  output m2h_back_stat_t stat
);

  typedef enum logic [2:0] {
    ST_RUN = 3'b001,
    ST_FIN = 3'b010,
    ST_OUT = 3'b100
  } m2h_state_t;

  m2h_state_t  state_r, state_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic [31:0] fin_r;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r;

  logic [31:0] h0;
  logic [31:0] mul_in;
  logic [31:0] prod;
  logic [31:0] h_new;
  logic [31:0] fin_in;
  logic [31:0] fin_prod;
  logic        out_load;

  assign h0       = q_op.first ? q_op.init : hash_r;
  assign mul_in   = (q_op.kind == OP_TAIL) ? (h0 ^ q_op.data) : h0;
  assign prod     = mul_in * MIX_MUL;
  assign fin_in   = hash_r ^ (hash_r >> FIN_SHIFT_A);
  assign fin_prod = fin_in * MIX_MUL;

  always_comb begin
    unique case (q_op.kind)
      OP_FULL: h_new = prod ^ q_op.data;
      OP_TAIL: h_new = prod;
      OP_NONE: h_new = h0;
      default: h_new = h0;
    endcase
  end

  assign q_pop    = (state_r == ST_RUN) && !q_empty;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || pop);

  always_comb begin
    state_nxt     = state_r;
    hash_nxt      = hash_r;
    out_valid_nxt = out_valid_r && !pop;
    unique case (state_r)
      ST_RUN: begin
        if (q_pop) begin
          hash_nxt = h_new;
          if (q_op.last) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      hash_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN) begin
      fin_r <= fin_prod;
    end
    if (out_load) begin
      out_hash_r <= fin_r ^ (fin_r >> FIN_SHIFT_B);
    end
  end

  assign empty           = !out_valid_r;
  assign out_hash_value  = out_hash_r;
  assign stat.popping    = q_pop;
  assign stat.finalising = (state_r != ST_RUN);

endmodule

[test/tb_murmur2_hash_stream_top.sv]
// Self-checking testbench for the streamed 32-bit MurmurHash2 block.
// Needs m2h_pkg and murmur2_hash_stream_top; everything else is generated here.
module tb_murmur2_hash_stream_top;
  timeunit 1ns;
  timeprecision 1ps;

  import m2h_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int LONG_HOLD      = 300;
  localparam int PHASE_WORDS    = 100;
  localparam int NUM_PHASES     = 5;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  count;
    logic        first;
    logic        last;
    logic [31:0] length;
  } word_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] in_data_word = '0;
  logic [2:0]  in_byte_count = '0;
  logic        in_first_word = 1'b0;
  logic        in_last_word = 1'b0;
  logic [31:0] in_message_length = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] out_hash_value;

  word_item_t  pending_words[$];
  logic [31:0] expected_hashes[$];

  // Private copy of the block's state for prediction.
  logic [31:0] model_seed = SEED_RESET;
  logic [31:0] model_hash = '0;
  bit          model_open = 1'b0;

  bit idle_en = 1'b1;
  int hold_requests = 0;
  int hold_served = 0;
  int send_gap = 0;
  int recv_stall = 0;
  int idle_cycles = 0;
  int words_accepted = 0;
  int hashes_checked = 0;
  int seed_writes = 0;
  int errors = 0;

  murmur2_hash_stream_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .push             (push),
    .full             (full),
    .in_data_word     (in_data_word),
    .in_byte_count    (in_byte_count),
    .in_first_word    (in_first_word),
    .in_last_word     (in_last_word),
    .in_message_length(in_message_length),
    .empty            (empty),
    .pop              (pop),
    .out_hash_value   (out_hash_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Absorbs one accepted word into the running hash; returns 1 with the
  // finalised hash when the word closes a message.
  function automatic bit absorb_word(input word_item_t it, output logic [31:0] hash_out);
    logic [31:0] h;
    logic [31:0] k;
    hash_out = '0;
    if (it.first) begin
      model_hash = model_seed ^ it.length;
      model_open = 1'b1;
    end else if (!model_open) begin
      return 1'b0;
    end
    h = model_hash;
    if (it.count >= 3'd4) begin
      k = it.word * MIX_MUL;
      k = k ^ (k >> MIX_SHIFT);
      k = k * MIX_MUL;
      h = h * MIX_MUL;
      h = h ^ k;
    end else if (it.count != 3'd0) begin
      h = h ^ (it.word & (32'hffff_ffff >> (8 * (4 - it.count))));
      h = h * MIX_MUL;
    end
    model_hash = h;
    if (!it.last) return 1'b0;
    h = h ^ (h >> FIN_SHIFT_A);
    h = h * MIX_MUL;
    h = h ^ (h >> FIN_SHIFT_B);
    hash_out = h;
    model_open = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] MISMATCH %s: got %08h, expected %08h", $time, what, got, want);
    errors++;
  endtask

  function automatic void add_item(input logic [31:0] w, input logic [2:0] c, input bit f,
                                   input bit l, input logic [31:0] n);
    word_item_t it;
    it.word   = w;
    it.count  = c;
    it.first  = f;
    it.last   = l;
    it.length = n;
    pending_words.push_back(it);
  endfunction

  // Splits a message of nbytes into words; the length field on later words
  // is junk, since the block samples it only with the first word.
  function automatic int queue_message(input int nbytes, input logic [31:0] len_field,
                                       input bit close);
    int nwords;
    int cnt;
    nwords = (nbytes + 3) / 4;
    if (nwords == 0) nwords = 1;
    for (int i = 0; i < nwords; i++) begin
      cnt = nbytes - 4 * i;
      if (cnt > 4) cnt = 4;
      if (cnt == 4 && $urandom_range(0, 7) == 0) cnt = $urandom_range(5, 7);
      add_item($urandom, cnt[2:0], i == 0, close && (i == nwords - 1),
               (i == 0) ? len_field : $urandom);
    end
    return nwords;
  endfunction

  function automatic int queue_random_message();
    int nbytes;
    logic [31:0] len_field;
    nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80) : $urandom_range(0, 24);
    len_field = ($urandom_range(0, 7) == 0) ? $urandom : nbytes;
    return queue_message(nbytes, len_field, 1'b1);
  endfunction

  task automatic queue_random_words(input int target);
    int made;
    int kind;
    made = 0;
    while (made < target) begin
      kind = $urandom_range(0, 15);
      if (kind <= 9) begin
        made += queue_random_message();
      end else if (kind <= 11) begin
        // Stray word while no message is open: the block drops it.
        add_item($urandom, 3'($urandom_range(0, 7)), 1'b0, 1'($urandom_range(0, 1)),
                 $urandom);
      end else if (kind <= 13) begin
        // Message cut short, then restarted by a fresh first word.
        made += queue_message($urandom_range(1, 20), $urandom, 1'b0);
        made += queue_random_message();
      end else if (kind == 14) begin
        // Short or empty word in the middle of a message.
        add_item($urandom, 3'd4, 1'b1, 1'b0, $urandom);
        add_item($urandom, 3'($urandom_range(0, 3)), 1'b0, 1'b0, $urandom);
        add_item($urandom, 3'd4, 1'b0, 1'b0, $urandom);
        add_item($urandom, 3'($urandom_range(1, 4)), 1'b0, 1'b1, $urandom);
        made += 4;
      end else begin
        add_item($urandom, 3'($urandom_range(0, 7)), 1'b1, 1'b1, $urandom);
        made += 1;
      end
    end
  endtask

  task automatic queue_directed_words();
    add_item(32'h0000_0000, 3'd4, 1'b1, 1'b1, 32'd4);
    add_item(32'hffff_ffff, 3'd4, 1'b1, 1'b1, 32'hffff_ffff);
    add_item($urandom, 3'd0, 1'b1, 1'b1, 32'd0);
    add_item(32'hffff_ffff, 3'd1, 1'b1, 1'b1, 32'd1);
    add_item(32'hffff_ffff, 3'd2, 1'b1, 1'b1, 32'd2);
    add_item(32'hffff_ffff, 3'd3, 1'b1, 1'b1, 32'd3);
    add_item(32'hffff_ffff, 3'd5, 1'b1, 1'b1, 32'd4);
    add_item(32'h8000_0001, 3'd7, 1'b1, 1'b1, 32'd4);
    // Stray closing word with no open message.
    add_item(32'hffff_ffff, 3'd4, 1'b0, 1'b1, 32'd0);
    add_item($urandom, 3'd4, 1'b1, 1'b0, 32'd9);
    add_item($urandom, 3'd2, 1'b0, 1'b0, $urandom);
    add_item($urandom, 3'd3, 1'b0, 1'b1, $urandom);
    add_item($urandom, 3'd4, 1'b1, 1'b0, 32'd8);
    add_item($urandom, 3'd4, 1'b1, 1'b0, 32'd8);
    add_item($urandom, 3'd4, 1'b0, 1'b1, 32'hffff_ffff);
    add_item($urandom, 3'd4, 1'b1, 1'b0, 32'd8);
    add_item($urandom, 3'd0, 1'b0, 1'b0, $urandom);
    add_item($urandom, 3'd4, 1'b0, 1'b1, $urandom);
  endtask

  // Waits for every queued word to go in and every hash to come out, then
  // lets the pipeline settle in case trailing words are still in flight.
  task automatic wait_until_idle();
    while (pending_words.size() != 0 || expected_hashes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    model_seed = value;
    seed_writes++;
  endtask

  // Sender: accepted transactions are predicted at the rising edge.
  always @(posedge clk) begin
    word_item_t  it;
    logic [31:0] hv;
    if (rst_n && push && !full) begin
      it = pending_words.pop_front();
      words_accepted++;
      if (absorb_word(it, hv)) expected_hashes.push_back(hv);
    end
  end

  always @(negedge clk) begin
    logic next_push;
    next_push = 1'b0;
    if (rst_n) begin
      if (send_gap == 0 && idle_en && $urandom_range(0, 11) == 0)
        send_gap = $urandom_range(1, 16);
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_words.size() != 0) begin
        in_data_word      <= pending_words[0].word;
        in_byte_count     <= pending_words[0].count;
        in_first_word     <= pending_words[0].first;
        in_last_word      <= pending_words[0].last;
        in_message_length <= pending_words[0].length;
        next_push = 1'b1;
      end
    end
    push <= next_push;
  end

  // Receiver: results are checked at the rising edge.
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && pop && !empty) begin
      if (expected_hashes.size() == 0) begin
        report_mismatch("hash with no message pending", out_hash_value, 'x);
      end else begin
        want = expected_hashes.pop_front();
        if (out_hash_value !== want) report_mismatch("hash_value", out_hash_value, want);
        hashes_checked++;
      end
    end
  end

  always @(negedge clk) begin
    logic next_pop;
    next_pop = 1'b0;
    if (rst_n) begin
      if (hold_served != hold_requests) begin
        hold_served++;
        recv_stall = LONG_HOLD;
      end else if (recv_stall == 0 && idle_en && $urandom_range(0, 9) == 0) begin
        recv_stall = $urandom_range(1, 16);
      end
      if (recv_stall > 0) recv_stall--;
      else next_pop = 1'b1;
    end
    pop <= next_pop;
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) ||
        (pending_words.size() == 0 && expected_hashes.size() == 0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] Watchdog: no transaction for %0d cycles", $time, idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] seed_value;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_directed_words();
    wait_until_idle();

    for (int phase = 1; phase <= NUM_PHASES; phase++) begin
      case (phase)
        1: seed_value = 32'h0000_0000;
        2: seed_value = 32'hffff_ffff;
        default: seed_value = $urandom;
      endcase
      write_seed(seed_value);
      // The last phase runs flat out on both sides.
      if (phase == NUM_PHASES) idle_en = 1'b0;
      // Long receiver hold so that the block backs up and raises full.
      if (phase == 2) hold_requests++;
      queue_random_words(PHASE_WORDS);
      wait_until_idle();
    end

    while (expected_hashes.size() != 0)
      report_mismatch("hash never produced", 'x, expected_hashes.pop_front());

    $display("Run covered %0d accepted words and %0d checked hashes under %0d seed values,",
             words_accepted, hashes_checked, seed_writes + 1);
    $display("including a long output hold and a final stretch with no idling; %0d mismatches.",
             errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
sv/m2h_pkg.sv
sv/m2h_front.sv
sv/m2h_queue.sv
sv/m2h_back.sv
sv/murmur2_hash_stream_top.sv
test/tb_murmur2_hash_stream_top.sv
